// ----- design/dec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_pkg: shared types and constants of the directory entry checker
// Field layouts, status codes, mode codes and the type index table.
// ----------------------------------------------------------------------------
package dec_pkg;

    localparam int MAX_ENTRIES_DEF = 256;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    // format modes
    localparam logic [1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_NEW     = 2'd1;
    localparam logic [1:0] MODE_OLD     = 2'd2;

    // status codes
    localparam logic [4:0] ST_OK_NEW       = 5'd0;
    localparam logic [4:0] ST_OK_OLD       = 5'd1;
    localparam logic [4:0] ST_END          = 5'd2;
    localparam logic [4:0] ST_RESV_BITS    = 5'd3;
    localparam logic [4:0] ST_OLD_OFFSET   = 5'd4;
    localparam logic [4:0] ST_NO_MARKER    = 5'd5;
    localparam logic [4:0] ST_ALIGN_TYPE   = 5'd6;
    localparam logic [4:0] ST_SUBDIR_TYPE  = 5'd7;
    localparam logic [4:0] ST_CART_SIZE    = 5'd8;
    localparam logic [4:0] ST_BANK_RANGE   = 5'd9;
    localparam logic [4:0] ST_SIZE_RANGE   = 5'd10;
    localparam logic [4:0] ST_OLD_TYPE     = 5'd11;
    localparam logic [4:0] ST_PRG_OFFSET   = 5'd12;
    localparam logic [4:0] ST_PRG_SIZE     = 5'd13;
    localparam logic [4:0] ST_SIZE_8K      = 5'd14;
    localparam logic [4:0] ST_SIZE_16K     = 5'd15;
    localparam logic [4:0] ST_OCEAN_512K   = 5'd16;
    localparam logic [4:0] ST_OCEAN_SIZE   = 5'd17;
    localparam logic [4:0] ST_UNSUPPORTED  = 5'd18;
    localparam logic [4:0] ST_UNKNOWN_TYPE = 5'd19;
    localparam logic [4:0] ST_NO_FS        = 5'd20;

    // entry type codes
    localparam logic [4:0] TYPE_NONE      = 5'h00;
    localparam logic [4:0] TYPE_PRG       = 5'h01;
    localparam logic [4:0] TYPE_PRG2      = 5'h02;
    localparam logic [4:0] TYPE_PRG3      = 5'h03;
    localparam logic [4:0] TYPE_CRT_8K    = 5'h10;
    localparam logic [4:0] TYPE_CRT_16K   = 5'h11;
    localparam logic [4:0] TYPE_ULT_16K   = 5'h12;
    localparam logic [4:0] TYPE_ULT_8K    = 5'h13;
    localparam logic [4:0] TYPE_OCEAN_512 = 5'h14;
    localparam logic [4:0] TYPE_OCEAN     = 5'h15;
    localparam logic [4:0] TYPE_UNSUPP    = 5'h1a;
    localparam logic [4:0] TYPE_XBANK     = 5'h1c;
    localparam logic [4:0] TYPE_XBANK2    = 5'h1d;
    localparam logic [4:0] TYPE_EF        = 5'h1e;
    localparam logic [4:0] TYPE_END       = 5'h1f;

    localparam logic [15:0] BANK_MAX      = 16'h003f;
    localparam logic [23:0] SIZE_MAX      = 24'h07ffff;
    localparam logic [15:0] PRG_OFFS_MAX  = 16'h3fff;
    localparam logic [23:0] PRG_SIZE_MAX  = 24'h00efff;
    localparam logic [23:0] SIZE_8K       = 24'h002000;
    localparam logic [23:0] SIZE_16K      = 24'h004000;
    localparam logic [23:0] SIZE_32K      = 24'h008000;
    localparam logic [23:0] SIZE_128K     = 24'h020000;
    localparam logic [23:0] SIZE_256K     = 24'h040000;
    localparam logic [23:0] SIZE_512K     = 24'h080000;

    typedef struct packed {
        logic        first_entry;
        logic [7:0]  flags_byte;
        logic [15:0] bank_word;
        logic [15:0] offset_word;
        logic [23:0] size_value;
    } item_t;

    typedef struct packed {
        logic [4:0]        status;
        logic              old_format;
        logic [3:0]        type_index;
        logic              hidden_flag;
        logic              subdir_flag;
        logic              align_flag;
        logic [7:0]        other_bank_count;
        logic [4:0]        other_bank_offset;
        logic signed [8:0] bank_count;
        logic [8:0]        entry_count;
    } result_t;

    typedef struct packed {
        logic       clear;
        logic       accept;
        logic [1:0] mode;
    } state_upd_t;

    function automatic logic [3:0] type_index(input logic [4:0] t);
        logic [3:0] idx;
        case (t)
            TYPE_NONE:      idx = 4'd0;
            TYPE_PRG:       idx = 4'd1;
            TYPE_PRG2:      idx = 4'd2;
            TYPE_PRG3:      idx = 4'd3;
            TYPE_CRT_8K:    idx = 4'd4;
            TYPE_CRT_16K:   idx = 4'd5;
            TYPE_ULT_16K:   idx = 4'd6;
            TYPE_ULT_8K:    idx = 4'd7;
            TYPE_OCEAN_512: idx = 4'd8;
            TYPE_OCEAN:     idx = 4'd9;
            TYPE_UNSUPP:    idx = 4'd10;
            TYPE_EF:        idx = 4'd11;
            TYPE_XBANK:     idx = 4'd12;
            TYPE_XBANK2:    idx = 4'd13;
            default:        idx = 4'd0;
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ----- design/dec_rules.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_rules: entry rule checks and decode
// Runs one entry through the rule chain against the current mode and count,
// producing the result word and the state update.
// ----------------------------------------------------------------------------
module dec_rules (
    input  wire dec_pkg::item_t      item,
    input  wire logic [1:0]          mode_cur,
    input  wire logic [8:0]          count_cur,
    output dec_pkg::result_t         result,
    output dec_pkg::state_upd_t      upd
);
    import dec_pkg::*;

    logic [1:0]  mode;
    logic [8:0]  count;
    logic [4:0]  etype;
    logic [15:0] offs;
    logic [23:0] size;
    logic        is_cart;
    logic        is_old;
    logic        was_old;
    logic [4:0]  type_st;
    logic [4:0]  st;

    // first entry clears state before the check
    assign mode    = item.first_entry ? MODE_UNKNOWN : mode_cur;
    assign count   = item.first_entry ? 9'd0 : count_cur;
    assign etype   = item.flags_byte[4:0];
    assign offs    = item.offset_word;
    assign size    = item.size_value;
    assign is_cart = etype[4];
    assign is_old  = (item.flags_byte[6:5] != 2'b11);
    assign was_old = (mode == MODE_OLD);

    always_comb begin
        case (etype)
            TYPE_NONE: begin
                type_st = ST_OK_NEW;
            end
            TYPE_PRG, TYPE_PRG2, TYPE_PRG3: begin
                if (offs > PRG_OFFS_MAX) begin
                    type_st = ST_PRG_OFFSET;
                end else if (size > PRG_SIZE_MAX) begin
                    type_st = ST_PRG_SIZE;
                end else begin
                    type_st = ST_OK_NEW;
                end
            end
            TYPE_CRT_8K, TYPE_ULT_8K: begin
                type_st = (!is_old && size != SIZE_8K) ? ST_SIZE_8K : ST_OK_NEW;
            end
            TYPE_CRT_16K, TYPE_ULT_16K: begin
                type_st = (!is_old && size != SIZE_16K) ? ST_SIZE_16K : ST_OK_NEW;
            end
            TYPE_OCEAN_512: begin
                type_st = (size != SIZE_512K) ? ST_OCEAN_512K : ST_OK_NEW;
            end
            TYPE_OCEAN: begin
                type_st = (size == SIZE_32K || size == SIZE_128K || size == SIZE_256K)
                          ? ST_OK_NEW : ST_OCEAN_SIZE;
            end
            TYPE_XBANK, TYPE_XBANK2, TYPE_EF: begin
                type_st = ST_OK_NEW;
            end
            TYPE_UNSUPP: begin
                type_st = ST_UNSUPPORTED;
            end
            default: begin
                type_st = ST_UNKNOWN_TYPE;
            end
        endcase
    end

    always_comb begin
        if (is_old && mode == MODE_NEW) begin
            st = ST_RESV_BITS;
        end else if (etype == TYPE_END) begin
            st = (mode == MODE_UNKNOWN) ? ST_NO_FS : ST_END;
        end else if (is_cart && offs != 16'd0 && (is_old || was_old)) begin
            st = ST_OLD_OFFSET;
        end else if (is_cart && !is_old && !offs[15]) begin
            st = ST_NO_MARKER;
        end else if (is_cart && !is_old && offs[13] && etype < TYPE_XBANK) begin
            st = ST_ALIGN_TYPE;
        end else if (is_cart && !is_old && offs[14]
                     && !(etype == TYPE_UNSUPP || etype >= TYPE_XBANK)) begin
            st = ST_SUBDIR_TYPE;
        end else if (is_cart && size[12:0] != 13'd0) begin
            st = ST_CART_SIZE;
        end else if (item.bank_word > BANK_MAX) begin
            st = ST_BANK_RANGE;
        end else if (size > SIZE_MAX) begin
            st = ST_SIZE_RANGE;
        end else if (is_old && (etype > TYPE_ULT_8K
                     || (etype > TYPE_PRG && etype < TYPE_CRT_8K))) begin
            st = ST_OLD_TYPE;
        end else if (type_st != ST_OK_NEW) begin
            st = type_st;
        end else begin
            st = is_old ? ST_OK_OLD : ST_OK_NEW;
        end
    end

    always_comb begin
        result = '0;
        result.status = st;
        if (st == ST_OK_OLD) begin
            result.old_format = 1'b1;
        end
        if (st == ST_END) begin
            result.entry_count = count;
        end
        if (st == ST_OK_NEW) begin
            result.type_index  = type_index(etype);
            result.hidden_flag = item.flags_byte[7];
            if (is_cart) begin
                result.subdir_flag       = offs[14];
                result.align_flag        = offs[13];
                result.other_bank_count  = offs[7:0];
                result.other_bank_offset = offs[12:8];
                result.bank_count        = size[21:13] - {1'b0, offs[7:0]};
            end
        end
    end

    assign upd.clear  = item.first_entry;
    assign upd.accept = (st == ST_OK_NEW) || (st == ST_OK_OLD);
    assign upd.mode   = is_old ? MODE_OLD : MODE_NEW;

endmodule
`default_nettype wire

// ----- design/directory_entry_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// directory_entry_checker: cartridge directory entry rule checker
// Throughput: one word per cycle while the result stream is not stalled; the
// rule chain sits between the input register and the result register, with
// mode and count updated on the same edge. Reset (aresetn low, synchronous)
// clears the valid flags of both stages, the mode and the count.
// ----------------------------------------------------------------------------
module directory_entry_checker #(
    parameter int MAX_ENTRIES = dec_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // flags_byte, bank_word, offset_word, size_value
    input  wire logic [dec_pkg::S_TDATA_W-1:0]  s_tdata,
    // first_entry
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status, type_index, hidden_flag, subdir_flag, align_flag,
    // other_bank_count, other_bank_offset, bank_count, entry_count, zero pad
    output logic [dec_pkg::M_TDATA_W-1:0]       m_tdata,
    // old_format
    output logic                                m_tuser
);
    import dec_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic          in_valid_reg;
    item_t         in_item_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    logic [1:0]    mode_reg;
    logic [1:0]    mode_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_base;
    logic          advance;
    result_t       res;
    state_upd_t    upd;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dec_rules u_rules (
        .item      (in_item_reg),
        .mode_cur  (mode_reg),
        .count_cur (9'(count_reg)),
        .result    (res),
        .upd       (upd)
    );

    always_comb begin
        mode_next  = mode_reg;
        count_base = upd.clear ? '0 : count_reg;
        count_next = count_reg;
        if (advance) begin
            if (upd.clear) begin
                mode_next = MODE_UNKNOWN;
            end
            count_next = count_base;
            if (upd.accept) begin
                mode_next = upd.mode;
                if (count_base < CW'(MAX_ENTRIES)) begin
                    count_next = count_base + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_UNKNOWN;
            count_reg     <= '0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.first_entry <= s_tuser;
            in_item_reg.flags_byte  <= s_tdata[7:0];
            in_item_reg.bank_word   <= s_tdata[23:8];
            in_item_reg.offset_word <= s_tdata[39:24];
            in_item_reg.size_value  <= s_tdata[63:40];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.old_format;
    assign m_tdata  = {5'd0,
                       out_reg.entry_count,
                       out_reg.bank_count,
                       out_reg.other_bank_offset,
                       out_reg.other_bank_count,
                       out_reg.align_flag,
                       out_reg.subdir_flag,
                       out_reg.hidden_flag,
                       out_reg.type_index,
                       out_reg.status};

endmodule
`default_nettype wire

// ----- dv/tb_directory_entry_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directory_entry_checker: self-checking bench for the directory checker
// Directed entries hit every decode path and every rule but ST_OLD_TYPE.
// Random directories follow, mostly well-formed with some corrupted or raw words.
// Each word is predicted on input handshake and compared field by field on the
// result stream, under varying source/sink throttling plus one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_directory_entry_checker;
    import dec_pkg::*;

    localparam int          IDLE_LIMIT     = 4000;
    localparam int          HOLD_AT        = 150;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_CYCLES   = 10;
    localparam logic [4:0]  TYPE_UNDEFINED = 5'h05;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    item_t   entries_to_send[$];
    result_t expected_results[$];
    item_t   offered;

    logic [1:0] dir_mode  = MODE_UNKNOWN;
    int         dir_count = 0;

    int send_idle_pct  = 27;
    int recv_idle_pct  = 80;
    int items_queued   = 0;
    int words_in       = 0;
    int idle_cycles    = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit in_fire        = 1'b0;
    bit out_fire       = 1'b0;
    int mismatch_count = 0;

    always #6 aclk = ~aclk;

    directory_entry_checker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Expected result of one entry; updates the tracked mode and count.
    function automatic result_t judge_entry(input item_t it);
        result_t     r;
        logic [4:0]  ty;
        logic [15:0] offs;
        logic [23:0] size;
        logic        resv_ok;
        logic        is_old;
        logic        was_old;
        logic        is_cart;
        logic [4:0]  st;
        logic [11:0] banks;
        r       = '0;
        ty      = it.flags_byte[4:0];
        offs    = it.offset_word;
        size    = it.size_value;
        resv_ok = (it.flags_byte[6:5] == 2'b11);
        is_old  = !resv_ok;
        is_cart = ty[4];
        if (it.first_entry) begin
            dir_mode  = MODE_UNKNOWN;
            dir_count = 0;
        end
        if (ty == TYPE_END) begin
            if (!resv_ok && dir_mode == MODE_NEW) begin
                r.status = ST_RESV_BITS;
            end else if (dir_mode == MODE_UNKNOWN) begin
                r.status = ST_NO_FS;
            end else begin
                r.status      = ST_END;
                r.entry_count = 9'(dir_count);
            end
            return r;
        end
        was_old = (dir_mode == MODE_OLD);
        if (!resv_ok && dir_mode == MODE_NEW)
            st = ST_RESV_BITS;
        else if (is_cart && offs != 16'h0 && (is_old || was_old))
            st = ST_OLD_OFFSET;
        else if (is_cart && !is_old && !offs[15])
            st = ST_NO_MARKER;
        else if (is_cart && !is_old && offs[13] && ty < TYPE_XBANK)
            st = ST_ALIGN_TYPE;
        else if (is_cart && !is_old && offs[14] && !(ty == TYPE_UNSUPP || ty >= TYPE_XBANK))
            st = ST_SUBDIR_TYPE;
        else if (is_cart && size[12:0] != 13'h0)
            st = ST_CART_SIZE;
        else if (it.bank_word > BANK_MAX)
            st = ST_BANK_RANGE;
        else if (size > SIZE_MAX)
            st = ST_SIZE_RANGE;
        else if (is_old && (ty > TYPE_ULT_8K || (ty > TYPE_PRG && ty < TYPE_CRT_8K)))
            st = ST_OLD_TYPE;
        else begin
            case (ty)
                TYPE_NONE, TYPE_XBANK, TYPE_XBANK2, TYPE_EF: st = ST_OK_NEW;
                TYPE_PRG, TYPE_PRG2, TYPE_PRG3: begin
                    if (offs > PRG_OFFS_MAX)
                        st = ST_PRG_OFFSET;
                    else if (size > PRG_SIZE_MAX)
                        st = ST_PRG_SIZE;
                    else
                        st = ST_OK_NEW;
                end
                TYPE_CRT_8K, TYPE_ULT_8K:
                    st = (!is_old && size != SIZE_8K) ? ST_SIZE_8K : ST_OK_NEW;
                TYPE_CRT_16K, TYPE_ULT_16K:
                    st = (!is_old && size != SIZE_16K) ? ST_SIZE_16K : ST_OK_NEW;
                TYPE_OCEAN_512:
                    st = (size != SIZE_512K) ? ST_OCEAN_512K : ST_OK_NEW;
                TYPE_OCEAN:
                    st = (size == SIZE_32K || size == SIZE_128K || size == SIZE_256K) ?
                         ST_OK_NEW : ST_OCEAN_SIZE;
                TYPE_UNSUPP: st = ST_UNSUPPORTED;
                default:     st = ST_UNKNOWN_TYPE;
            endcase
        end
        if (st != ST_OK_NEW) begin
            r.status = st;
            return r;
        end
        dir_mode = is_old ? MODE_OLD : MODE_NEW;
        if (dir_count < MAX_ENTRIES_DEF)
            dir_count++;
        if (is_old) begin
            r.status     = ST_OK_OLD;
            r.old_format = 1'b1;
            return r;
        end
        r.status = ST_OK_NEW;
        case (ty)
            TYPE_PRG:       r.type_index = 4'd1;
            TYPE_PRG2:      r.type_index = 4'd2;
            TYPE_PRG3:      r.type_index = 4'd3;
            TYPE_CRT_8K:    r.type_index = 4'd4;
            TYPE_CRT_16K:   r.type_index = 4'd5;
            TYPE_ULT_16K:   r.type_index = 4'd6;
            TYPE_ULT_8K:    r.type_index = 4'd7;
            TYPE_OCEAN_512: r.type_index = 4'd8;
            TYPE_OCEAN:     r.type_index = 4'd9;
            TYPE_UNSUPP:    r.type_index = 4'd10;
            TYPE_EF:        r.type_index = 4'd11;
            TYPE_XBANK:     r.type_index = 4'd12;
            TYPE_XBANK2:    r.type_index = 4'd13;
            default:        r.type_index = 4'd0;
        endcase
        r.hidden_flag = it.flags_byte[7];
        if (is_cart) begin
            banks               = {1'b0, size[23:13]} - {4'b0, offs[7:0]};
            r.subdir_flag       = offs[14];
            r.align_flag        = offs[13];
            r.other_bank_count  = offs[7:0];
            r.other_bank_offset = offs[12:8];
            r.bank_count        = banks[8:0];
        end
        return r;
    endfunction

    function automatic item_t dir_item(input bit first, input bit hidden,
                                       input logic [1:0] resv, input logic [4:0] ty,
                                       input logic [15:0] bank, input logic [15:0] offs,
                                       input logic [23:0] size);
        item_t it;
        it.first_entry = first;
        it.flags_byte  = {hidden, resv, ty};
        it.bank_word   = bank;
        it.offset_word = offs;
        it.size_value  = size;
        return it;
    endfunction

    function automatic item_t good_new_entry();
        logic [4:0]  ty;
        logic [15:0] offs;
        logic [23:0] size;
        case ($urandom_range(0, 12))
            0:       ty = TYPE_NONE;
            1:       ty = TYPE_PRG;
            2:       ty = TYPE_PRG2;
            3:       ty = TYPE_PRG3;
            4:       ty = TYPE_CRT_8K;
            5:       ty = TYPE_CRT_16K;
            6:       ty = TYPE_ULT_16K;
            7:       ty = TYPE_ULT_8K;
            8:       ty = TYPE_OCEAN_512;
            9:       ty = TYPE_OCEAN;
            10:      ty = TYPE_XBANK;
            11:      ty = TYPE_XBANK2;
            default: ty = TYPE_EF;
        endcase
        offs = {3'b100, 13'($urandom)};
        case (ty)
            TYPE_NONE: begin
                offs = 16'($urandom);
                size = 24'($urandom_range(0, 'h7ffff));
            end
            TYPE_PRG, TYPE_PRG2, TYPE_PRG3: begin
                offs = 16'($urandom_range(0, 'h3fff));
                size = 24'($urandom_range(0, 'hefff));
            end
            TYPE_CRT_8K, TYPE_ULT_8K:   size = SIZE_8K;
            TYPE_CRT_16K, TYPE_ULT_16K: size = SIZE_16K;
            TYPE_OCEAN_512:             size = SIZE_512K;
            TYPE_OCEAN: begin
                case ($urandom_range(0, 2))
                    0:       size = SIZE_32K;
                    1:       size = SIZE_128K;
                    default: size = SIZE_256K;
                endcase
            end
            default: begin
                offs = {1'b1, 15'($urandom)};
                size = {5'b0, 6'($urandom), 13'b0};
            end
        endcase
        return dir_item(1'b0, 1'($urandom), 2'b11, ty, 16'($urandom_range(0, 63)), offs, size);
    endfunction

    function automatic item_t good_old_entry();
        logic [4:0]  ty;
        logic [15:0] offs;
        logic [23:0] size;
        case ($urandom_range(0, 5))
            0:       ty = TYPE_NONE;
            1:       ty = TYPE_PRG;
            2:       ty = TYPE_CRT_8K;
            3:       ty = TYPE_CRT_16K;
            4:       ty = TYPE_ULT_16K;
            default: ty = TYPE_ULT_8K;
        endcase
        if (ty == TYPE_NONE) begin
            offs = 16'($urandom);
            size = 24'($urandom_range(0, 'h7ffff));
        end else if (ty == TYPE_PRG) begin
            offs = 16'($urandom_range(0, 'h3fff));
            size = 24'($urandom_range(0, 'hefff));
        end else begin
            offs = 16'h0;
            size = {5'b0, 6'($urandom), 13'b0};
        end
        return dir_item(1'b0, 1'($urandom), 2'($urandom_range(0, 2)), ty,
                        16'($urandom_range(0, 63)), offs, size);
    endfunction

    // Corrupt an entry: either fully random content or one flipped bit.
    function automatic item_t broken(input item_t it);
        int pos;
        if ($urandom_range(0, 3) == 0) begin
            it = 65'({$urandom, $urandom, $urandom});
        end else begin
            pos     = $urandom_range(0, 63);
            it[pos] = ~it[pos];
        end
        return it;
    endfunction

    task automatic queue_entry(input item_t it);
        entries_to_send.push_back(it);
        items_queued++;
    endtask

    task automatic queue_directory(input int len, input bit old_style);
        item_t it;
        for (int i = 0; i < len; i++) begin
            if (old_style && $urandom_range(0, 19) != 0)
                it = good_old_entry();
            else
                it = good_new_entry();
            if ($urandom_range(0, 99) < 12)
                it = broken(it);
            it.first_entry = (i == 0);
            queue_entry(it);
        end
        it = 65'({$urandom, $urandom, $urandom});
        it.first_entry = 1'b0;
        it.flags_byte[4:0] = TYPE_END;
        if ($urandom_range(0, 9) != 0)
            it.flags_byte[6:5] = 2'b11;
        queue_entry(it);
    endtask

    task automatic queue_random(input int n);
        int start;
        start = items_queued;
        while (items_queued - start < n) begin
            if ($urandom_range(0, 99) < 80)
                queue_directory($urandom_range(1, 12), $urandom_range(0, 2) == 0);
            else
                queue_entry(broken(good_new_entry()));
        end
    endtask

    task automatic queue_directed();
        queue_entry(dir_item(1'b0, 1'b1, 2'b11, TYPE_END, 16'hffff, 16'hffff, 24'hffffff));
        queue_entry(dir_item(1'b1, 1'b1, 2'b11, TYPE_NONE, 16'h003f, 16'hffff, 24'h07ffff));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_PRG, 16'h0, 16'h3fff, 24'h00efff));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_PRG2, 16'h0, 16'h4000, 24'h0));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_PRG3, 16'h0, 16'h0, 24'h00f000));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_NONE, 16'h0040, 16'h0, 24'h0));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_NONE, 16'h0, 16'h0, 24'h080000));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_CRT_8K, 16'h0, 16'h0000, SIZE_8K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_CRT_8K, 16'h0, 16'ha000, SIZE_8K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_CRT_8K, 16'h0, 16'hc000, SIZE_8K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_CRT_8K, 16'h0, 16'h8000, 24'h002001));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_CRT_8K, 16'h0, 16'h8000, SIZE_16K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_ULT_16K, 16'h0, 16'h8000, SIZE_8K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_OCEAN_512, 16'h0, 16'h8000, SIZE_256K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_OCEAN, 16'h0, 16'h8000, 24'h010000));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_UNSUPP, 16'h0, 16'hc000, 24'h0));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_UNDEFINED, 16'h0, 16'h0, 24'h0));
        // negative bank count: 63 banks minus 255 opposite banks
        queue_entry(dir_item(1'b0, 1'b1, 2'b11, TYPE_XBANK, 16'h0, 16'hffff, 24'h07e000));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_CRT_16K, 16'h003f, 16'h80ff, SIZE_16K));
        // reserved bits cleared while the directory is new format
        queue_entry(dir_item(1'b0, 1'b0, 2'b00, TYPE_PRG, 16'h0, 16'h0, 24'h0));
        queue_entry(dir_item(1'b0, 1'b0, 2'b01, TYPE_END, 16'h0, 16'h0, 24'h0));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_END, 16'h0, 16'h0, 24'h0));
        // old-format directory, then switch to new format
        queue_entry(dir_item(1'b1, 1'b0, 2'b00, TYPE_NONE, 16'h0, 16'h0, 24'h0));
        queue_entry(dir_item(1'b0, 1'b0, 2'b10, TYPE_CRT_8K, 16'h0, 16'h0001, SIZE_8K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_CRT_8K, 16'h0, 16'h8000, SIZE_8K));
        queue_entry(dir_item(1'b0, 1'b1, 2'b01, TYPE_OCEAN_512, 16'h0, 16'h0, SIZE_512K));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_NONE, 16'h0, 16'h0, 24'h0));
        queue_entry(dir_item(1'b0, 1'b0, 2'b11, TYPE_END, 16'h0, 16'h0, 24'h0));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (entries_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered = entries_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {offered.size_value, offered.offset_word,
                             offered.bank_word, offered.flags_byte};
                s_tuser  <= offered.first_entry;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        in_fire  = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (in_fire) begin
            expected_results.push_back(judge_entry(offered));
            words_in++;
        end
        if (out_fire) begin
            got.status            = m_tdata[4:0];
            got.type_index        = m_tdata[8:5];
            got.hidden_flag       = m_tdata[9];
            got.subdir_flag       = m_tdata[10];
            got.align_flag        = m_tdata[11];
            got.other_bank_count  = m_tdata[19:12];
            got.other_bank_offset = m_tdata[24:20];
            got.bank_count        = m_tdata[33:25];
            got.entry_count       = m_tdata[42:34];
            got.old_format        = m_tuser;
            if (expected_results.size() == 0) begin
                $error("unexpected result word, status %0d", got.status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("old_format", want.old_format, got.old_format);
                check_field("type_index", want.type_index, got.type_index);
                check_field("hidden_flag", want.hidden_flag, got.hidden_flag);
                check_field("subdir_flag", want.subdir_flag, got.subdir_flag);
                check_field("align_flag", want.align_flag, got.align_flag);
                check_field("other_bank_count", want.other_bank_count, got.other_bank_count);
                check_field("other_bank_offset", want.other_bank_offset,
                            got.other_bank_offset);
                check_field("bank_count", int'($signed(want.bank_count)),
                            int'($signed(got.bank_count)));
                check_field("entry_count", want.entry_count, got.entry_count);
            end
        end
        if (aresetn) begin
            idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAIL directory_entry_checker");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        queue_random(360);
        while (entries_to_send.size() != 0) @(posedge aclk);

        send_idle_pct = 80;
        recv_idle_pct = 27;
        queue_random(360);
        while (entries_to_send.size() != 0) @(posedge aclk);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long directory drives the entry count into saturation
        queue_directory(320, 1'b0);
        queue_random(360);

        while (entries_to_send.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d result words never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASS directory_entry_checker");
        end else begin
            $display("FAIL directory_entry_checker");
        end
        $finish;
    end

endmodule
